// ----- hdl/sal_pkg.sv -----
// Shared types, constants and helper functions of the sorted linked-list block.
package sal_pkg;

  localparam int NODE_COUNT = 64;
  localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int LINK_W     = IDX_W + 1;
  localparam int CNT_W      = IDX_W + 1;
  localparam int KEY_W      = 32;
  localparam int POS_W      = 7;
  localparam int STATUS_W   = 3;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [LINK_W-1:0]        link_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [KEY_W-1:0]  key_t;
  typedef logic signed [POS_W-1:0]  pos_t;

  localparam link_t LINK_NULL = {LINK_W{1'b1}};
  localparam pos_t  POS_NULL  = {POS_W{1'b1}};
  localparam cnt_t  CNT_NODES = CNT_W'(NODE_COUNT);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_MISSING   = 3'd4
  } status_t;

  // A link is a node only when it lies inside the store; anything else is null.
  function automatic logic node_valid(input link_t n);
    return n < LINK_W'(NODE_COUNT);
  endfunction

  // Link held by an entry that has never been written: the next node, or null.
  function automatic link_t link_reset(input idx_t i);
    link_t nxt;
    nxt = LINK_W'(i) + LINK_W'(1);
    if (node_valid(nxt)) begin
      return nxt;
    end
    return LINK_NULL;
  endfunction

  // Node index as it appears on the result channel.
  function automatic pos_t enc_pos(input link_t n);
    if (!node_valid(n)) begin
      return POS_NULL;
    end
    return POS_W'(n);
  endfunction

endpackage

// ----- hdl/sal_in_if.sv -----
// Request channel: operation kind and key.
interface sal_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  sal_pkg::key_t     key;

  modport source (output valid, kind, key, input ready);
  modport sink   (input valid, kind, key, output ready);
endinterface

// ----- hdl/sal_out_if.sv -----
// Result channel: status, node position and predecessor.
interface sal_out_if;
  logic              valid;
  logic              ready;
  sal_pkg::status_t  status;
  sal_pkg::pos_t     position;
  sal_pkg::pos_t     predecessor;

  modport source (output valid, status, position, predecessor, input ready);
  modport sink   (input valid, status, position, predecessor, output ready);
endinterface

// ----- hdl/sorted_array_linked_list.sv -----
// Top level: list walk sequencer, insert relinking and result register.
//
//   Channel   Direction  Handshake         Payload
//   in_ch     sink       valid / ready     kind, key
//   out_ch    source     valid / ready     status, position, predecessor
//
// An item visits at most NODE_COUNT nodes in the walk, then passes the resolve and done
// states; an insert that links after an existing node adds the relink state between them,
// and a list that holds every node takes no insert.
// The walk takes one node per cycle, as the key and link RAMs have registered reads.
// Reset empties the list at once; the link store needs no clearing pass, as a fill
// mark supplies the reset links. One item is in work at a time; a result waiting
// on out_ch holds the sequencer in its final state until the slot frees.
module sorted_array_linked_list (
  input  logic      clk,
  input  logic      rst_n,
  sal_in_if.sink    in_ch,
  sal_out_if.source out_ch
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_WALK    = 5'b00010,
    S_RESOLVE = 5'b00100,
    S_WR_PREV = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic              kind_r, kind_nxt;
  sal_pkg::key_t     key_r, key_nxt;
  sal_pkg::link_t    cur_r, cur_nxt;
  sal_pkg::link_t    prev_r, prev_nxt;
  sal_pkg::cnt_t     steps_r, steps_nxt;
  logic              hit_r, hit_nxt;
  sal_pkg::link_t    head_r, head_nxt;
  sal_pkg::cnt_t     fill_r, fill_nxt;
  sal_pkg::idx_t     node_r, node_nxt;
  sal_pkg::status_t  res_status_r, res_status_nxt;
  sal_pkg::pos_t     res_pos_r, res_pos_nxt;
  sal_pkg::pos_t     res_pred_r, res_pred_nxt;
  logic              out_valid_r, out_valid_nxt;
  sal_pkg::status_t  out_status_r, out_status_nxt;
  sal_pkg::pos_t     out_pos_r, out_pos_nxt;
  sal_pkg::pos_t     out_pred_r, out_pred_nxt;

  logic              rd_en;
  sal_pkg::idx_t     rd_addr;
  logic              kwr_en;
  logic              lwr_en;
  sal_pkg::idx_t     lwr_addr;
  sal_pkg::link_t    lwr_data;
  sal_pkg::key_t     key_q;
  sal_pkg::link_t    link_q;
  sal_pkg::cnt_t     steps_inc;
  logic              free_ok;
  sal_pkg::idx_t     free_node;

  sal_key_ram u_key_ram (
    .clk     (clk),
    .wr_en   (kwr_en),
    .wr_addr (free_node),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (key_q)
  );

  sal_link_ram u_link_ram (
    .clk     (clk),
    .fill    (fill_r),
    .wr_en   (lwr_en),
    .wr_addr (lwr_addr),
    .wr_data (lwr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (link_q)
  );

  assign steps_inc = steps_r + sal_pkg::CNT_W'(1);
  assign free_ok   = fill_r < sal_pkg::CNT_NODES;
  assign free_node = fill_r[sal_pkg::IDX_W-1:0];

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.predecessor = out_pred_r;

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    steps_nxt      = steps_r;
    hit_nxt        = hit_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    node_nxt       = node_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_pred_nxt   = res_pred_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_pred_nxt   = out_pred_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    kwr_en         = 1'b0;
    lwr_en         = 1'b0;
    lwr_addr       = '0;
    lwr_data       = sal_pkg::LINK_NULL;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt  = in_ch.kind;
          key_nxt   = in_ch.key;
          prev_nxt  = sal_pkg::LINK_NULL;
          steps_nxt = '0;
          cur_nxt   = head_r;
          hit_nxt   = 1'b0;
          if (sal_pkg::node_valid(head_r)) begin
            rd_en     = 1'b1;
            rd_addr   = head_r[sal_pkg::IDX_W-1:0];
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_RESOLVE;
          end
        end
      end

      S_WALK: begin
        // The read of cur_r has landed; the next node's read goes out in the same cycle.
        if (key_q >= key_r) begin
          hit_nxt   = (key_q == key_r);
          state_nxt = S_RESOLVE;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = link_q;
          steps_nxt = steps_inc;
          if (sal_pkg::node_valid(link_q) && (steps_inc < sal_pkg::CNT_NODES)) begin
            rd_en   = 1'b1;
            rd_addr = link_q[sal_pkg::IDX_W-1:0];
          end else begin
            state_nxt = S_RESOLVE;
          end
        end
      end

      S_RESOLVE: begin
        res_pred_nxt = sal_pkg::enc_pos(prev_r);
        state_nxt    = S_DONE;
        if (kind_r == sal_pkg::KIND_LOOKUP) begin
          res_status_nxt = hit_r ? sal_pkg::ST_FOUND : sal_pkg::ST_MISSING;
          res_pos_nxt    = hit_r ? sal_pkg::enc_pos(cur_r) : sal_pkg::POS_NULL;
        end else if (!free_ok) begin
          res_status_nxt = sal_pkg::ST_FULL;
          res_pos_nxt    = sal_pkg::POS_NULL;
        end else if (hit_r) begin
          res_status_nxt = sal_pkg::ST_DUPLICATE;
          res_pos_nxt    = sal_pkg::enc_pos(cur_r);
        end else begin
          // Pop the free head, store the key and point the new node at the stop point.
          res_status_nxt = sal_pkg::ST_INSERTED;
          res_pos_nxt    = sal_pkg::enc_pos(sal_pkg::LINK_W'(free_node));
          kwr_en         = 1'b1;
          lwr_en         = 1'b1;
          lwr_addr       = free_node;
          lwr_data       = sal_pkg::node_valid(head_r) ? cur_r : sal_pkg::LINK_NULL;
          fill_nxt       = fill_r + sal_pkg::CNT_W'(1);
          node_nxt       = free_node;
          if (sal_pkg::node_valid(prev_r)) begin
            state_nxt = S_WR_PREV;
          end else begin
            head_nxt = sal_pkg::LINK_W'(free_node);
          end
        end
      end

      S_WR_PREV: begin
        lwr_en    = 1'b1;
        lwr_addr  = prev_r[sal_pkg::IDX_W-1:0];
        lwr_data  = sal_pkg::LINK_W'(node_r);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = res_pos_r;
          out_pred_nxt   = res_pred_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= sal_pkg::LINK_NULL;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    steps_r      <= steps_nxt;
    hit_r        <= hit_nxt;
    node_r       <= node_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_pred_r   <= res_pred_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_pred_r   <= out_pred_nxt;
  end

  // The fill mark doubles as the free head and never passes the store size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= sal_pkg::CNT_NODES)
    else $error("fill mark beyond node store");

  // A key is only written while a free node exists.
  a_key_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    kwr_en |-> free_ok)
    else $error("key written with no free node");

  // Linking after a predecessor only happens with a real predecessor node.
  a_prev_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR_PREV) |-> sal_pkg::node_valid(prev_r))
    else $error("relink with null predecessor");

  // An accepted item goes straight into the walk or the resolve step.
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_WALK || state_r == S_RESOLVE))
    else $error("accepted item did not start");

endmodule

// ----- hdl/sal_key_ram.sv -----
// Key store: one write port, one registered read port.
module sal_key_ram (
  input  logic                clk,
  input  logic                wr_en,
  input  sal_pkg::idx_t       wr_addr,
  input  sal_pkg::key_t       wr_data,
  input  logic                rd_en,
  input  sal_pkg::idx_t       rd_addr,
  output sal_pkg::key_t       rd_data
);

  sal_pkg::key_t mem [sal_pkg::NODE_COUNT];
  sal_pkg::key_t q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  assign rd_data = q_r;

endmodule

// ----- hdl/sal_link_ram.sv -----
// Link store with a fill mark: entries at or above the mark read as their reset link.
module sal_link_ram (
  input  logic                clk,
  input  sal_pkg::cnt_t       fill,
  input  logic                wr_en,
  input  sal_pkg::idx_t       wr_addr,
  input  sal_pkg::link_t      wr_data,
  input  logic                rd_en,
  input  sal_pkg::idx_t       rd_addr,
  output sal_pkg::link_t      rd_data
);

  sal_pkg::link_t mem [sal_pkg::NODE_COUNT];
  sal_pkg::link_t q_r;
  sal_pkg::idx_t  addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r    <= mem[rd_addr];
      addr_r <= rd_addr;
    end
  end

  // Nodes are handed out in index order, so every entry below the mark has been written.
  assign rd_data = (sal_pkg::CNT_W'(addr_r) < fill) ? q_r : sal_pkg::link_reset(addr_r);

endmodule

// ----- tb/sv/tb_sorted_array_linked_list.sv -----
// Testbench for the sorted linked-list block: directed and random inserts and lookups.
`timescale 1ns / 100ps

module tb_sorted_array_linked_list;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  typedef struct packed {
    sal_pkg::status_t status;
    sal_pkg::pos_t    position;
    sal_pkg::pos_t    predecessor;
  } list_result_t;

  logic clk;
  logic rst_n;

  sal_in_if  in_if();
  sal_out_if out_if();

  sorted_array_linked_list u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Shadow copy of the node store, kept in step with every accepted item.
  sal_pkg::key_t node_key  [sal_pkg::NODE_COUNT];
  int            node_link [sal_pkg::NODE_COUNT];
  int            head_node;
  int            free_node;

  list_result_t  pending_results[$];
  sal_pkg::key_t known_keys[$];
  int            mismatch_count = 0;
  int            quiet_cycles   = 0;
  bit            idle_on        = 1'b1;
  int            hold_requests  = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic bit in_store(input int n);
    return n >= 0 && n < sal_pkg::NODE_COUNT;
  endfunction

  function automatic sal_pkg::pos_t to_pos(input int n);
    if (n < 0) begin
      return sal_pkg::POS_NULL;
    end
    return sal_pkg::pos_t'(n);
  endfunction

  // Walks the shadow list, applies an insert and returns the result the block must give.
  function automatic list_result_t predict_result(input logic kind, input sal_pkg::key_t key);
    int           cur;
    int           prev;
    int           steps;
    int           hit;
    int           n;
    bit           walking;
    list_result_t r;
    cur     = head_node;
    prev    = -1;
    steps   = 0;
    walking = 1'b1;
    while (walking && in_store(cur) && steps < sal_pkg::NODE_COUNT) begin
      if (node_key[cur] >= key) begin
        walking = 1'b0;
      end else begin
        prev  = cur;
        cur   = node_link[cur];
        steps = steps + 1;
      end
    end
    hit = (in_store(cur) && steps < sal_pkg::NODE_COUNT && node_key[cur] == key) ? cur : -1;
    r.predecessor = to_pos(prev);
    if (kind == sal_pkg::KIND_LOOKUP) begin
      r.status   = (hit >= 0) ? sal_pkg::ST_FOUND : sal_pkg::ST_MISSING;
      r.position = to_pos(hit);
    end else if (!in_store(free_node)) begin
      // A full store refuses the insert even when the key is already present.
      r.status   = sal_pkg::ST_FULL;
      r.position = sal_pkg::POS_NULL;
    end else if (hit >= 0) begin
      r.status   = sal_pkg::ST_DUPLICATE;
      r.position = to_pos(hit);
    end else begin
      n           = free_node;
      free_node   = node_link[n];
      node_key[n] = key;
      if (!in_store(head_node)) begin
        node_link[n] = -1;
        head_node    = n;
      end else if (!in_store(prev)) begin
        node_link[n] = head_node;
        head_node    = n;
      end else begin
        node_link[n]    = node_link[prev];
        node_link[prev] = n;
      end
      r.status   = sal_pkg::ST_INSERTED;
      r.position = to_pos(n);
    end
    return r;
  endfunction

  // A key that is likely new: a full-width random value, a small value, or a neighbour.
  function automatic sal_pkg::key_t fresh_key();
    sal_pkg::key_t k;
    case ($urandom_range(0, 2))
      0: k = $urandom;
      1: begin
        k = $urandom_range(0, 200);
        k = k - 100;
      end
      default: begin
        if (known_keys.size() == 0) begin
          k = $urandom;
        end else begin
          k = known_keys[$urandom_range(0, known_keys.size() - 1)];
          k = ($urandom_range(0, 1) == 0) ? k + 1 : k - 1;
        end
      end
    endcase
    return k;
  endfunction

  function automatic sal_pkg::key_t known_key();
    if (known_keys.size() == 0) begin
      return fresh_key();
    end
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // Offers one item and records its expected result once the block takes it.
  task automatic send_item(input logic kind, input sal_pkg::key_t key);
    int           gap;
    list_result_t want;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.key   <= key;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    want = predict_result(kind, key);
    if (kind == sal_pkg::KIND_INSERT && want.status == sal_pkg::ST_INSERTED) begin
      known_keys.push_back(key);
    end
    pending_results.push_back(want);
  endtask

  task automatic test_directed();
    send_item(sal_pkg::KIND_LOOKUP, 32'sh8000_0000);
    send_item(sal_pkg::KIND_INSERT, 32'sh0000_0000);
    send_item(sal_pkg::KIND_INSERT, 32'sh0000_0000);
    send_item(sal_pkg::KIND_INSERT, 32'sh8000_0000);
    send_item(sal_pkg::KIND_INSERT, 32'sh7FFF_FFFF);
    send_item(sal_pkg::KIND_INSERT, 32'shFFFF_FFFF);
    send_item(sal_pkg::KIND_INSERT, 32'sh0000_0001);
    send_item(sal_pkg::KIND_LOOKUP, 32'sh0000_0000);
    send_item(sal_pkg::KIND_LOOKUP, 32'sh8000_0000);
    send_item(sal_pkg::KIND_LOOKUP, 32'sh7FFF_FFFF);
    send_item(sal_pkg::KIND_LOOKUP, 32'shFFFF_FFFF);
    send_item(sal_pkg::KIND_LOOKUP, 32'sh0000_0001);
    send_item(sal_pkg::KIND_LOOKUP, 32'sh0000_0002);
    send_item(sal_pkg::KIND_LOOKUP, 32'shFFFF_FFFE);
    send_item(sal_pkg::KIND_INSERT, 32'sh7FFF_FFFF);
    send_item(sal_pkg::KIND_INSERT, 32'sh8000_0000);
    send_item(sal_pkg::KIND_LOOKUP, 32'sh5555_5555);
    send_item(sal_pkg::KIND_LOOKUP, 32'shAAAA_AAAA);
  endtask

  // The receiver stops taking results for a long stretch while items keep coming.
  task automatic test_back_pressure();
    idle_on       = 1'b0;
    hold_requests = hold_requests + 1;
    repeat (12) begin
      send_item(($urandom_range(0, 1) == 0) ? sal_pkg::KIND_INSERT : sal_pkg::KIND_LOOKUP,
                known_key());
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random_mix(input int count, input int new_pct);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < new_pct) begin
        send_item(sal_pkg::KIND_INSERT, fresh_key());
      end else begin
        case ($urandom_range(0, 2))
          0:       send_item(sal_pkg::KIND_LOOKUP, known_key());
          1:       send_item(sal_pkg::KIND_LOOKUP, fresh_key());
          default: send_item(sal_pkg::KIND_INSERT, known_key());
        endcase
      end
    end
    idle_on = 1'b1;
  endtask

  // Inserts new keys until no node is free, then probes the full store.
  task automatic test_fill_store();
    while (in_store(free_node)) begin
      send_item(sal_pkg::KIND_INSERT, fresh_key());
    end
    send_item(sal_pkg::KIND_INSERT, fresh_key());
    send_item(sal_pkg::KIND_INSERT, known_key());
    send_item(sal_pkg::KIND_LOOKUP, known_key());
  endtask

  // Result side: random stalls, the long hold when asked, and the field checks.
  initial begin
    int           stall;
    int           holds_served;
    list_result_t want;
    holds_served = 0;
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_requests > holds_served) begin
        stall        = HOLD_CYCLES;
        holds_served = holds_served + 1;
      end else begin
        stall = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, status %0d position %0d predecessor %0d",
                 $time, out_if.status, out_if.position, out_if.predecessor);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_if.status);
          mismatch_count++;
        end
        if (out_if.position !== want.position) begin
          $display("%0t: position mismatch, expected %0d, actual %0d",
                   $time, want.position, out_if.position);
          mismatch_count++;
        end
        if (out_if.predecessor !== want.predecessor) begin
          $display("%0t: predecessor mismatch, expected %0d, actual %0d",
                   $time, want.predecessor, out_if.predecessor);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("FAIL sorted_array_linked_list");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind  = sal_pkg::KIND_INSERT;
    in_if.key   = '0;
    for (int i = 0; i < sal_pkg::NODE_COUNT; i++) begin
      node_key[i]  = '0;
      node_link[i] = (i + 1 < sal_pkg::NODE_COUNT) ? i + 1 : -1;
    end
    head_node = -1;
    free_node = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_back_pressure();
    test_random_mix(900, 5);
    test_fill_store();
    test_random_mix(350, 30);

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS sorted_array_linked_list");
    end else begin
      $display("FAIL sorted_array_linked_list");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sal_pkg.sv
hdl/sal_in_if.sv
hdl/sal_out_if.sv
hdl/sal_key_ram.sv
hdl/sal_link_ram.sv
hdl/sorted_array_linked_list.sv
tb/sv/tb_sorted_array_linked_list.sv
